>>> hw/rtl/mts_pkg.sv
// Shared types and constants for the min-tracking stack.
package mts_pkg;

    localparam int DATA_W = 32;
    localparam int STAT_W = 2;
    localparam int FILL_W = 7;

    localparam logic ACT_PUSH = 1'b0;
    localparam logic ACT_POP  = 1'b1;

    localparam logic [STAT_W-1:0] STATUS_OK    = 2'd0;
    localparam logic [STAT_W-1:0] STATUS_EMPTY = 2'd1;
    localparam logic [STAT_W-1:0] STATUS_FULL  = 2'd2;

    // controller -> datapath
    typedef struct packed {
        logic load_in;   // capture the input word
        logic exec;      // do push, or start pop
        logic pop_chk;   // popped word is back from the value store
        logic min_ld;    // new min top is back from the min store
        logic emit;      // load the output register
    } t_cmd;

    // datapath -> controller
    typedef struct packed {
        logic pop_go;    // current op is a pop on a non-empty stack
        logic min_hit;   // popped word matches the min top
    } t_sts;

endpackage

>>> hw/rtl/mts_if.sv
// Valid/ready channel interfaces for the input and output words.
interface mts_in_if import mts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic              action;
    logic [DATA_W-1:0] value;

    modport source (output valid, output action, output value, input ready);
    modport sink   (input valid, input action, input value, output ready);
endinterface

interface mts_out_if import mts_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [DATA_W-1:0] popped_value;
    logic [STAT_W-1:0] status;
    logic [DATA_W-1:0] current_min;
    logic              min_valid;
    logic [FILL_W-1:0] fill_level;

    modport source (output valid, output popped_value, output status,
                    output current_min, output min_valid, output fill_level,
                    input ready);
    modport sink   (input valid, input popped_value, input status,
                    input current_min, input min_valid, input fill_level,
                    output ready);
endinterface

>>> hw/rtl/min_tracking_stack.sv
// Top level of the min-tracking stack: channels, sequencer and datapath.
// One word in flight: the next word is accepted only after the last one's
// result is loaded into the output register, which takes exec and emit per
// word plus the registered reads of a pop, and a min store re-read when the
// popped word was the current minimum.
// Reset (synchronous, active low) empties both stores and the output register;
// store contents are left as they are and used only below the counts.
module min_tracking_stack import mts_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  logic       i_clk,
    input  logic       i_rst_n,
    mts_in_if.sink     i_in,
    mts_out_if.source  o_out
);

    t_cmd w_cmd;
    t_sts w_sts;

    // Sequencer: accepts only in idle, holds each word until the output
    // register is free, so the consumer can stall without losing results.
    mts_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (w_sts),
        .o_cmd       (w_cmd),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid)
    );

    // Datapath: the min top lives in a register, so a push compares against
    // it and updates it in the exec state; a pop reads the top word back, and
    // on a match with the min top reloads it from the entry below in the min store.
    mts_dpath #(
        .STACK_DEPTH (STACK_DEPTH)
    ) u_dpath (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_cmd          (w_cmd),
        .i_action       (i_in.action),
        .i_value        (i_in.value),
        .o_sts          (w_sts),
        .o_popped_value (o_out.popped_value),
        .o_status       (o_out.status),
        .o_current_min  (o_out.current_min),
        .o_min_valid    (o_out.min_valid),
        .o_fill_level   (o_out.fill_level)
    );

endmodule

>>> hw/rtl/mts_ctrl.sv
// Sequencer for the min-tracking stack: one word at a time.
module mts_ctrl import mts_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd,
    output logic o_in_ready,
    output logic o_out_valid
);

    localparam logic [2:0] S_IDLE   = 3'd0;
    localparam logic [2:0] S_EXEC   = 3'd1;
    localparam logic [2:0] S_POPCHK = 3'd2;
    localparam logic [2:0] S_MINLD  = 3'd3;
    localparam logic [2:0] S_EMIT   = 3'd4;

    logic [2:0] r_state, n_state;
    logic       r_ovalid, n_ovalid;
    logic       w_slot_free;

    assign w_slot_free = !r_ovalid || i_out_ready;

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.load_in = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                n_state    = i_sts.pop_go ? S_POPCHK : S_EMIT;
            end
            S_POPCHK: begin
                o_cmd.pop_chk = 1'b1;
                n_state       = i_sts.min_hit ? S_MINLD : S_EMIT;
            end
            S_MINLD: begin
                o_cmd.min_ld = 1'b1;
                n_state      = S_EMIT;
            end
            S_EMIT: begin
                if (w_slot_free) begin
                    o_cmd.emit = 1'b1;
                    n_state    = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_comb begin
        n_ovalid = r_ovalid;
        if (o_cmd.emit) begin
            n_ovalid = 1'b1;
        end else if (i_out_ready) begin
            n_ovalid = 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_ovalid <= n_ovalid;
        end
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_ovalid;

    // a result never overwrites one that is still waiting
    a_no_overwrite: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |-> w_slot_free)
        else $error("output overwritten");

    // an emit returns the sequencer to idle with a result word held
    a_emit_then_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_cmd.emit |=> (r_state == S_IDLE) && r_ovalid)
        else $error("emit did not return to idle with a result");

    // a stalled result word stays valid
    a_hold_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_valid && !i_out_ready) |=> o_out_valid)
        else $error("result word dropped while stalled");

endmodule

>>> hw/rtl/mts_dpath.sv
// Stack datapath: value and min stores, counts, min top and output register.
module mts_dpath import mts_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    input  logic              i_action,
    input  logic [DATA_W-1:0] i_value,
    output t_sts              o_sts,
    output logic [DATA_W-1:0] o_popped_value,
    output logic [STAT_W-1:0] o_status,
    output logic [DATA_W-1:0] o_current_min,
    output logic              o_min_valid,
    output logic [FILL_W-1:0] o_fill_level
);

    localparam int AW = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
    localparam int CW = $clog2(STACK_DEPTH + 1);

    logic [DATA_W-1:0] r_vmem [STACK_DEPTH];
    logic [DATA_W-1:0] r_mmem [STACK_DEPTH];

    logic              r_act;
    logic [DATA_W-1:0] r_val;
    logic [DATA_W-1:0] r_popped;
    logic [STAT_W-1:0] r_stat;
    logic [CW-1:0]     r_vcnt;
    logic [CW-1:0]     r_mcnt;
    logic [DATA_W-1:0] r_min_top;
    logic [DATA_W-1:0] r_vrd;
    logic [DATA_W-1:0] r_mrd;

    logic [CW-1:0] w_vcnt_dec;
    logic [CW-1:0] w_mcnt_dec2;
    logic          w_full;
    logic          w_empty;
    logic          w_min_push;
    logic          w_push_ok;

    assign w_vcnt_dec  = r_vcnt - CW'(1);
    assign w_mcnt_dec2 = r_mcnt - CW'(2);
    assign w_full      = (r_vcnt == CW'(STACK_DEPTH));
    assign w_empty     = (r_vcnt == '0);
    assign w_push_ok   = i_cmd.exec && (r_act == ACT_PUSH) && !w_full;
    assign w_min_push  = ((r_mcnt == '0) || ($signed(r_val) <= $signed(r_min_top)))
                         && (r_mcnt != CW'(STACK_DEPTH));

    assign o_sts.pop_go  = (r_act == ACT_POP) && !w_empty;
    assign o_sts.min_hit = (r_mcnt != '0) && (r_vrd == r_min_top);

    // stores: one write port each, registered reads at the value top and below the min top
    always_ff @(posedge i_clk) begin
        if (w_push_ok) begin
            r_vmem[r_vcnt[AW-1:0]] <= r_val;
            if (w_min_push) begin
                r_mmem[r_mcnt[AW-1:0]] <= r_val;
            end
        end
        r_vrd <= r_vmem[w_vcnt_dec[AW-1:0]];
        r_mrd <= r_mmem[w_mcnt_dec2[AW-1:0]];
    end

    // counts
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vcnt <= '0;
            r_mcnt <= '0;
        end else begin
            if (w_push_ok) begin
                r_vcnt <= r_vcnt + CW'(1);
                if (w_min_push) begin
                    r_mcnt <= r_mcnt + CW'(1);
                end
            end else if (i_cmd.exec && o_sts.pop_go) begin
                r_vcnt <= w_vcnt_dec;
            end
            if (i_cmd.pop_chk && o_sts.min_hit) begin
                r_mcnt <= r_mcnt - CW'(1);
            end
        end
    end

    // per-word payload
    always_ff @(posedge i_clk) begin
        if (i_cmd.load_in) begin
            r_act    <= i_action;
            r_val    <= i_value;
            r_popped <= '0;
            r_stat   <= STATUS_OK;
        end
        if (i_cmd.exec) begin
            if ((r_act == ACT_PUSH) && w_full) begin
                r_stat <= STATUS_FULL;
            end else if ((r_act == ACT_POP) && w_empty) begin
                r_stat <= STATUS_EMPTY;
            end
        end
        if (w_push_ok && w_min_push) begin
            r_min_top <= r_val;
        end else if (i_cmd.min_ld) begin
            r_min_top <= r_mrd;
        end
        if (i_cmd.pop_chk) begin
            r_popped <= r_vrd;
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (i_cmd.emit) begin
            o_popped_value <= r_popped;
            o_status       <= r_stat;
            o_current_min  <= ((r_vcnt != '0) && (r_mcnt != '0)) ? r_min_top : '0;
            o_min_valid    <= (r_vcnt != '0);
            o_fill_level   <= FILL_W'(r_vcnt);
        end
    end

    // a pop lowers the value count in the cycle before the min count, so the
    // count relations are checked once the word has settled
    a_min_le_val: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> (r_mcnt <= r_vcnt))
        else $error("min count above value count");

    a_both_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.emit |-> ((r_vcnt == '0) == (r_mcnt == '0)))
        else $error("min store out of step with value store");

    a_push_count: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_push_ok |=> r_vcnt == $past(r_vcnt) + CW'(1))
        else $error("push did not advance the count");

    a_full_flag: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.emit && (r_stat == STATUS_FULL)) |-> w_full)
        else $error("full flagged on a stack with room");

endmodule

>>> dv/mts_stack_checker.sv
// Watches both channels of the min-tracking stack, predicts each result word and compares.
module mts_stack_checker import mts_pkg::*; #(
    parameter int STACK_DEPTH = 64
) (
    input  logic i_clk,
    input  logic i_rst_n,
    mts_in_if    i_in,
    mts_out_if   i_out,
    output int   o_fail_count,
    output int   o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [DATA_W-1:0] popped_value;
        logic [STAT_W-1:0] status;
        logic [DATA_W-1:0] current_min;
        logic              min_valid;
        logic [FILL_W-1:0] fill_level;
    } t_stack_word;

    logic signed [DATA_W-1:0] held   [STACK_DEPTH];
    logic signed [DATA_W-1:0] minima [STACK_DEPTH];
    int          n_held = 0;
    int          n_min  = 0;
    t_stack_word words_due [$];
    int          fail_count = 0;
    int          due_count  = 0;

    assign o_fail_count = fail_count;
    assign o_pending    = due_count;

    // one push or pop on the shadow stack; returns the word the block must give
    function automatic t_stack_word stack_step(logic act, logic signed [DATA_W-1:0] v);
        t_stack_word r;
        r        = '0;
        r.status = STATUS_OK;
        if (act == ACT_PUSH) begin
            if (n_held >= STACK_DEPTH) begin
                r.status = STATUS_FULL;
            end else begin
                held[n_held] = v;
                n_held++;
                // ties go onto the min store too, so duplicates unwind one for one
                if (n_min == 0 || v <= minima[n_min-1]) begin
                    if (n_min < STACK_DEPTH) begin
                        minima[n_min] = v;
                        n_min++;
                    end
                end
            end
        end else begin
            if (n_held == 0) begin
                r.status = STATUS_EMPTY;
            end else begin
                n_held--;
                r.popped_value = held[n_held];
                if (n_min > 0 && held[n_held] == minima[n_min-1])
                    n_min--;
            end
        end
        if (n_held > 0 && n_min > 0)
            r.current_min = minima[n_min-1];
        r.min_valid  = (n_held > 0);
        r.fill_level = n_held[FILL_W-1:0];
        return r;
    endfunction

    function automatic void diff_field(string name, logic [DATA_W-1:0] want,
                                       logic [DATA_W-1:0] got);
        if (want !== got) begin
            $error("%s mismatch: expected 'h%0h, actual 'h%0h", name, want, got);
            fail_count++;
        end
    endfunction

    always @(posedge i_clk) begin
        t_stack_word got;
        t_stack_word want;
        if (!i_rst_n) begin
            n_held = 0;
            n_min  = 0;
            words_due.delete();
        end else begin
            if (i_out.valid && i_out.ready) begin
                got.popped_value = i_out.popped_value;
                got.status       = i_out.status;
                got.current_min  = i_out.current_min;
                got.min_valid    = i_out.min_valid;
                got.fill_level   = i_out.fill_level;
                if (words_due.size() == 0) begin
                    $error("result word with no word pending");
                    fail_count++;
                end else begin
                    want = words_due.pop_front();
                    diff_field("popped_value", want.popped_value, got.popped_value);
                    diff_field("status", want.status, got.status);
                    diff_field("current_min", want.current_min, got.current_min);
                    diff_field("min_valid", want.min_valid, got.min_valid);
                    diff_field("fill_level", want.fill_level, got.fill_level);
                end
            end
            if (i_in.valid && i_in.ready)
                words_due.push_back(stack_step(i_in.action, i_in.value));
        end
        due_count = words_due.size();
    end

endmodule

>>> dv/tb_min_tracking_stack.sv
// Stimulus, clock, reset and verdict for the min-tracking stack.
module tb_min_tracking_stack;
    timeunit 1ns;
    timeprecision 1ps;
    import mts_pkg::*;

    localparam int DEPTH          = 64;
    localparam int RANDOM_WORDS   = 450;
    localparam int CALM_AFTER     = 400;   // no gaps or stalls past this many random words
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int DRAIN_CYCLES   = 10;

    // shape of one stretch of random traffic
    typedef enum logic [1:0] {SEG_FILL, SEG_DRAIN, SEG_MIX} t_segment;

    logic              i_clk;
    logic              i_rst_n;
    logic              calm;
    int                fails;
    int                pending;
    int                level_guess;   // rough fill, used only to steer the stimulus
    int                n_sent;
    int                stall_cycles = 0;
    logic [DATA_W-1:0] last_push;

    mts_in_if  in_ch  ();
    mts_out_if out_ch ();

    min_tracking_stack #(.STACK_DEPTH(DEPTH)) DUT (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_in    (in_ch),
        .o_out   (out_ch)
    );

    mts_stack_checker #(.STACK_DEPTH(DEPTH)) u_checker (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_in         (in_ch),
        .i_out        (out_ch),
        .o_fail_count (fails),
        .o_pending    (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Values lean on a small range and on the last push so that ties and
    // running minima stack up; full-range and extreme values cover every bit.
    function automatic logic [DATA_W-1:0] pick_value();
        logic [DATA_W-1:0] v;
        case ($urandom_range(0, 9))
            0, 1, 2, 3: v = $urandom_range(0, 16) - 8;
            4, 5, 6:    v = $urandom;
            7: begin
                case ($urandom_range(0, 3))
                    0:       v = 32'h8000_0000;
                    1:       v = 32'h7fff_ffff;
                    2:       v = '0;
                    default: v = '1;
                endcase
            end
            8:       v = last_push;                       // tie with a recent push
            default: v = last_push - $urandom_range(0, 3); // descending run
        endcase
        return v;
    endfunction

    // One word on the input channel. An optional gap with valid low comes
    // first; then hold valid until the block takes the word.
    task automatic send_word(logic act, logic [DATA_W-1:0] v);
        if (!calm && $urandom_range(0, 3) == 0) begin
            in_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 7)) @(posedge i_clk);
        end
        in_ch.valid  <= 1'b1;
        in_ch.action <= act;
        in_ch.value  <= v;
        @(posedge i_clk);
        while (!in_ch.ready) @(posedge i_clk);
        if (act == ACT_PUSH) begin
            last_push = v;
            if (level_guess < DEPTH) level_guess++;
        end else if (level_guess > 0) begin
            level_guess--;
        end
    endtask

    task automatic push_word(logic [DATA_W-1:0] v);
        send_word(ACT_PUSH, v);
    endtask

    // the value field of a pop is don't-care, so fill it with noise
    task automatic pop_word();
        send_word(ACT_POP, $urandom);
    endtask

    task automatic random_word(logic act);
        n_sent++;
        calm = (n_sent >= CALM_AFTER);
        if (act == ACT_PUSH) push_word(pick_value());
        else pop_word();
    endtask

    // Output side: ready drops in random bursts, never once calm.
    initial begin
        int stall;
        stall = 0;
        out_ch.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (stall > 0) begin
                stall--;
                out_ch.ready <= 1'b0;
            end else if (!calm && $urandom_range(0, 4) == 0) begin
                stall = $urandom_range(1, 7) - 1;
                out_ch.ready <= 1'b0;
            end else begin
                out_ch.ready <= 1'b1;
            end
        end
    end

    // Watchdog: too long without a word moving on either channel.
    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            stall_cycles <= 0;
        end else if (stall_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
        end else begin
            stall_cycles <= stall_cycles + 1;
        end
    end

    initial begin
        t_segment seg;
        int       extra;
        in_ch.valid  <= 1'b0;
        in_ch.action <= ACT_PUSH;
        in_ch.value  <= '0;
        i_rst_n      <= 1'b0;
        level_guess  = 0;
        last_push    = '0;
        calm         = 1'b0;
        n_sent       = 0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // --- directed ---
        pop_word();                 // pop on empty stack
        push_word(32'd5);
        push_word(32'd7);           // above the min: min store untouched
        push_word(32'd5);           // tie with the min: tracked again
        push_word(32'd3);
        pop_word();                 // removes the min, min goes back to 5
        pop_word();                 // removes one of the tied 5s, min stays 5
        pop_word();
        pop_word();                 // back to empty, min_valid drops
        pop_word();                 // empty again
        push_word(32'h7fff_ffff);
        push_word(32'h8000_0000);   // most negative becomes the min
        push_word(32'h8000_0000);   // tie at the extreme
        push_word(32'h0000_0000);
        push_word(32'hffff_ffff);
        repeat (5) pop_word();
        pop_word();

        // --- random ---
        // Always open with a fill so push-on-full is reached early; later
        // segments pick fill, drain or mixed traffic at random.
        seg = SEG_FILL;
        while (n_sent < RANDOM_WORDS) begin
            case (seg)
                SEG_FILL: begin
                    extra = $urandom_range(1, 4);   // pushes attempted at full
                    while (extra > 0 && n_sent < RANDOM_WORDS) begin
                        random_word(($urandom_range(0, 9) == 0) ? ACT_POP : ACT_PUSH);
                        if (level_guess == DEPTH) extra--;
                    end
                end
                SEG_DRAIN: begin
                    extra = $urandom_range(1, 3);   // pops attempted on empty
                    while (extra > 0 && n_sent < RANDOM_WORDS) begin
                        random_word(($urandom_range(0, 9) == 0) ? ACT_PUSH : ACT_POP);
                        if (level_guess == 0) extra--;
                    end
                end
                default: begin
                    repeat ($urandom_range(10, 40))
                        random_word($urandom_range(0, 1) ? ACT_POP : ACT_PUSH);
                end
            endcase
            seg = t_segment'($urandom_range(0, 2));
        end
        in_ch.valid <= 1'b0;

        // let the last word land in the checker before looking at the count
        @(posedge i_clk);
        wait (pending == 0);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (fails == 0 && pending == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

>>> files.f
hw/rtl/mts_pkg.sv
hw/rtl/mts_if.sv
hw/rtl/mts_ctrl.sv
hw/rtl/mts_dpath.sv
hw/rtl/min_tracking_stack.sv
dv/mts_stack_checker.sv
dv/tb_min_tracking_stack.sv
